// ----- rtl/vnu_pkg.sv -----
// Shared constants for the 3D vector normalization unit.
package vnu_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

endpackage

// ----- rtl/vnu_sqrt_cell.sv -----
// One digit step of the pipelined integer square root, with its payload register.
module vnu_sqrt_cell
    import vnu_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int SIDE_W     = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [2*COMP_WIDTH-1:0] rad_in,
    input  logic [COMP_WIDTH+2:0]   rem_in,
    input  logic [COMP_WIDTH-1:0]   root_in,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    valid_out,
    output logic [2*COMP_WIDTH-1:0] rad_out,
    output logic [COMP_WIDTH+2:0]   rem_out,
    output logic [COMP_WIDTH-1:0]   root_out,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int RW = COMP_WIDTH + 3;

    logic                    valid_reg;
    logic [2*COMP_WIDTH-1:0] rad_reg;
    logic [RW-1:0]           rem_reg, rem_next, rem_sh, trial;
    logic [COMP_WIDTH-1:0]   root_reg, root_next;
    logic [SIDE_W-1:0]       side_reg;
    logic                    take;

    always_comb
    begin
        // bring down the next two radicand bits and test root*4+1
        rem_sh = {rem_in[RW-3:0], rad_in[2*COMP_WIDTH-1 -: 2]};
        trial  = RW'({root_in, 2'b01});
        take   = (rem_sh >= trial);
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[COMP_WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[2*COMP_WIDTH-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ----- rtl/vnu_div_cell.sv -----
// One quotient-bit step of the three-lane restoring divider, with its payload register.
module vnu_div_cell
    import vnu_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter bit SHIFT      = 1'b1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  logic [COMP_WIDTH-1:0]     len_in,
    input  logic [3*COMP_WIDTH-1:0]   rem_in,
    input  logic [3*(FRAC_BITS+1)-1:0] quo_in,
    input  logic [3:0]                flag_in,
    output logic                      valid_out,
    output logic [COMP_WIDTH-1:0]     len_out,
    output logic [3*COMP_WIDTH-1:0]   rem_out,
    output logic [3*(FRAC_BITS+1)-1:0] quo_out,
    output logic [3:0]                flag_out
);

    localparam int QW = FRAC_BITS + 1;

    logic                    valid_reg;
    logic [COMP_WIDTH-1:0]   len_reg;
    logic [3*COMP_WIDTH-1:0] rem_reg, rem_next;
    logic [3*QW-1:0]         quo_reg, quo_next;
    logic [3:0]              flag_reg;

    always_comb
    begin
        logic [COMP_WIDTH:0] rs;
        logic [COMP_WIDTH:0] dv;
        logic                ge;
        rem_next = '0;
        quo_next = '0;
        dv = {1'b0, len_in};
        for (int i = 0; i < 3; i++)
        begin
            rs = SHIFT ? {rem_in[i*COMP_WIDTH +: COMP_WIDTH], 1'b0}
                       : {1'b0, rem_in[i*COMP_WIDTH +: COMP_WIDTH]};
            ge = (rs >= dv);
            rem_next[i*COMP_WIDTH +: COMP_WIDTH] = ge ? COMP_WIDTH'(rs - dv)
                                                      : COMP_WIDTH'(rs);
            quo_next[i*QW +: QW] = {quo_in[i*QW +: QW-1], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            flag_reg <= flag_in;
        end
    end

    assign valid_out = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign flag_out  = flag_reg;

endmodule

// ----- rtl/vector3_normalize_unit.sv -----
// Usage notes:
// Normalizes a signed 3D vector. The slave channel (s_axis_*) takes one request
// per cycle: comp_x, comp_y, comp_z packed in s_axis_tdata. The master channel
// (m_axis_*) returns the unit components in signed Q1.FRAC_BITS, truncated toward
// zero, plus the floored integer length; m_axis_tuser carries the zero-vector flag.
// Throughput: one vector per cycle while the receiver accepts. The chain has one
// square-root cell per result bit and one divider cell per quotient bit, plus
// input, square, sum and output registers.
// A zero vector gives length 0, zero_vector 1 and all-zero units.
// When the receiver stalls, the whole cell chain holds; s_axis_tready drops only
// while a finished result waits in the output register and cannot advance.
// Reset empties the chain; no clearing pass is needed.
module vector3_normalize_unit
    import vnu_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int UW    = FRAC_BITS + 2,
    localparam int IN_W  = ((3*COMP_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3*UW + COMP_WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // fields from bit 0: comp_x, comp_y, comp_z
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // fields from bit 0: unit_x, unit_y, unit_z, length
    output logic [OUT_W-1:0] m_axis_tdata,
    // fields from bit 0: zero_vector
    output logic             m_axis_tuser
);

    localparam int CW   = COMP_WIDTH;
    localparam int QW   = FRAC_BITS + 1;
    localparam int RW   = CW + 3;
    localparam int SIDE = 3*CW + 4;
    localparam int NDIV = FRAC_BITS + 1;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input stages: sign and magnitude, then squares, then their sum
    logic              v0_reg, v1_reg, v2_reg;
    logic [3*CW-1:0]   mag0_reg, mag1_reg, mag2_reg;
    logic [2:0]        neg0_reg, neg1_reg, neg2_reg;
    logic [2*CW-1:0]   sq1_reg [3];
    logic [2*CW-1:0]   sum2_reg;
    logic              zero2_reg;
    logic [3*CW-1:0]   mag_next;
    logic [2:0]        neg_next;

    always_comb
    begin
        logic [CW-1:0] c;
        mag_next = '0;
        neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            c = s_axis_tdata[i*CW +: CW];
            neg_next[i] = c[CW-1];
            mag_next[i*CW +: CW] = c[CW-1] ? (~c + 1'b1) : c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg <= mag_next;
            neg0_reg <= neg_next;
            for (int i = 0; i < 3; i++)
            begin
                sq1_reg[i] <= mag0_reg[i*CW +: CW] * mag0_reg[i*CW +: CW];
            end
            mag1_reg <= mag0_reg;
            neg1_reg <= neg0_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            zero2_reg <= (sq1_reg[0] == '0) && (sq1_reg[1] == '0) && (sq1_reg[2] == '0);
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // square-root chain
    logic            sv   [CW+1];
    logic [2*CW-1:0] srad [CW+1];
    logic [RW-1:0]   srem [CW+1];
    logic [CW-1:0]   sroot[CW+1];
    logic [SIDE-1:0] sside[CW+1];

    assign sv[0]    = v2_reg;
    assign srad[0]  = sum2_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sside[0] = {zero2_reg, neg2_reg, mag2_reg};

    for (genvar k = 0; k < CW; k++)
    begin : g_sqrt
        vnu_sqrt_cell #(.COMP_WIDTH(CW), .SIDE_W(SIDE)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(sv[k]), .rad_in(srad[k]), .rem_in(srem[k]),
            .root_in(sroot[k]), .side_in(sside[k]),
            .valid_out(sv[k+1]), .rad_out(srad[k+1]), .rem_out(srem[k+1]),
            .root_out(sroot[k+1]), .side_out(sside[k+1])
        );
    end

    // divider chain: first cell tests the unshifted magnitude
    logic            dv   [NDIV+1];
    logic [CW-1:0]   dlen [NDIV+1];
    logic [3*CW-1:0] drem [NDIV+1];
    logic [3*QW-1:0] dquo [NDIV+1];
    logic [3:0]      dflag[NDIV+1];

    assign dv[0]    = sv[CW];
    assign dlen[0]  = sroot[CW];
    assign drem[0]  = sside[CW][3*CW-1:0];
    assign dquo[0]  = '0;
    assign dflag[0] = sside[CW][SIDE-1 -: 4];

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        vnu_div_cell #(.COMP_WIDTH(CW), .FRAC_BITS(FRAC_BITS), .SHIFT(k != 0)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(dv[k]), .len_in(dlen[k]), .rem_in(drem[k]),
            .quo_in(dquo[k]), .flag_in(dflag[k]),
            .valid_out(dv[k+1]), .len_out(dlen[k+1]), .rem_out(drem[k+1]),
            .quo_out(dquo[k+1]), .flag_out(dflag[k+1])
        );
    end

    // output register: apply sign, force zero vector to zero units
    logic                   out_valid_reg;
    logic [3*UW+CW-1:0]     out_data_reg, out_data_next;
    logic                   out_zero_reg;

    always_comb
    begin
        logic [UW-1:0] q;
        out_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = {1'b0, dquo[NDIV][i*QW +: QW]};
            if (dflag[NDIV][3])
            begin
                q = '0;
            end
            else if (dflag[NDIV][i])
            begin
                q = ~q + 1'b1;
            end
            out_data_next[i*UW +: UW] = q;
        end
        out_data_next[3*UW +: CW] = dlen[NDIV];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_zero_reg <= dflag[NDIV][3];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_zero_reg;

`ifndef SYNTHESIS
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_zero_reg) |-> (out_data_reg == '0))
        else $error("zero vector result carries nonzero data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dv[NDIV] && !dflag[NDIV][3]) |->
        (dquo[NDIV][QW-1:0] <= (QW'(1) << FRAC_BITS)))
        else $error("unit x exceeds one");
`endif

endmodule
